// ===== rtl/lifnu_pkg.sv =====
// lifnu_pkg: shared types and constants of the lif neuron update unit
// no dependencies; imported by lif_neuron_update_unit

package lifnu_pkg;

    // population size default
    localparam int NUM_NEURONS_DEF = 1024;

    // payload field widths
    localparam int IDX_W   = 10;
    localparam int POT_W   = 32;
    localparam int STEP_W  = 32;
    localparam int DECAY_W = 16;
    localparam int REFR_W  = 16;

    // zero-extended index width, covers the largest population
    localparam int IDX_EXT_W = 17;

    // stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LVL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd4;

    // reset values of the configuration registers
    localparam logic [DECAY_W-1:0] DECAY_RST     = 16'hFFFF;
    localparam logic [POT_W-1:0]   THRESHOLD_RST = 32'h0001_0000;

    // neuron state word: potential, last spike step, spiked flag
    localparam int MEM_W = POT_W + STEP_W + 1;

    // remainder unit, one bit per cycle
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } lifnu_state_t;

endpackage

// ===== rtl/lif_neuron_update_unit.sv =====
// lif_neuron_update_unit: leaky integrate-and-fire population update, one neuron per beat
// depends on lifnu_pkg
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | neuron_index, dv_inc, step_num
//  m_axis    | out       | tvalid/tready          | out_index, spiked, was_refractory,
//            |           |                        | new_potential, saturated
//  cfg       | in        | cfg_wr_en, no wait     | cfg_index, cfg_wdata
//
// an item goes through accept with state memory read, multiply by decay,
// integrate and threshold, then write back and load the result register
// a mode-1 reset with threshold above reset level also runs through the
// bit-serial remainder unit that replaces the repeated subtraction
// after reset a clearing pass writes zero to all NUM_NEURONS entries, one a cycle,
// with s_axis_tready low; config writes are taken during it
// the next beat is accepted while a result waits in the output register; write
// back holds only when that register is still full

module lif_neuron_update_unit
    import lifnu_pkg::*;
#(
    parameter int NUM_NEURONS = NUM_NEURONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // [9:0] neuron_index, [41:10] dv_inc, [73:42] step_num, [79:74] zero
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,

    // [9:0] out_index, [10] spiked, [11] was_refractory,
    // [43:12] new_potential, [44] saturated, [47:45] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [DECAY_W-1:0]       decay_reg;
    logic signed [POT_W-1:0]  thr_reg;
    logic signed [POT_W-1:0]  rst_lvl_reg;
    logic [REFR_W-1:0]        refr_steps_reg;
    logic                     mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg      <= DECAY_RST;
            thr_reg        <= THRESHOLD_RST;
            rst_lvl_reg    <= '0;
            refr_steps_reg <= '0;
            mode_reg       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DECAY:     decay_reg      <= cfg_wdata[DECAY_W-1:0];
                CFG_THRESHOLD: thr_reg        <= cfg_wdata[POT_W-1:0];
                CFG_RESET_LVL: rst_lvl_reg    <= cfg_wdata[POT_W-1:0];
                CFG_REFR:      refr_steps_reg <= cfg_wdata[REFR_W-1:0];
                CFG_MODE:      mode_reg       <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    lifnu_state_t             state_reg, state_next;
    logic [AW-1:0]            clr_cnt_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;

    logic                     in_accept;
    logic                     out_free;
    logic                     load_out;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [MEM_W-1:0]         mem_wdata;

    // input item
    logic [IDX_W-1:0]         idx_reg;
    logic signed [POT_W-1:0]  dv_reg;
    logic [STEP_W-1:0]        now_reg;
    logic                     in_range_reg;

    // state word read at accept
    logic [MEM_W-1:0]         rd_reg;
    logic signed [POT_W-1:0]  rd_pot;
    logic [STEP_W-1:0]        rd_last;
    logic                     rd_has;

    // multiply stage
    logic signed [47:0]       prod_reg;
    logic                     refr_hit_reg;

    // integrate stage
    logic signed [POT_W-1:0]  v_reg;
    logic                     spk_reg;
    logic                     sat_reg;
    logic                     refr_flag_reg;
    logic                     div_used_reg;

    // remainder unit
    logic [POT_W-1:0]         num_reg;
    logic [POT_W-1:0]         den_reg;
    logic [POT_W-1:0]         rem_reg;

    // output register
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    assign rd_pot  = rd_reg[POT_W-1:0];
    assign rd_last = rd_reg[POT_W+STEP_W-1:POT_W];
    assign rd_has  = rd_reg[MEM_W-1];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // ---------------------------------------------------------------
    // integrate and threshold, combinational part of ST_ADD
    // ---------------------------------------------------------------
    logic signed [POT_W-1:0]  decayed;
    logic signed [POT_W:0]    sum_wide;
    logic signed [POT_W-1:0]  v_sat;
    logic                     sum_sat;
    logic                     spike;
    logic                     mode1_div;

    always_comb
    begin
        // floor of product / 2^16 is the arithmetic shift
        decayed  = prod_reg[47:16];
        sum_wide = {decayed[POT_W-1], decayed} + {dv_reg[POT_W-1], dv_reg};
        sum_sat  = 1'b0;
        v_sat    = sum_wide[POT_W-1:0];
        if (sum_wide[POT_W] != sum_wide[POT_W-1])
        begin
            sum_sat = 1'b1;
            v_sat   = sum_wide[POT_W] ? {1'b1, {(POT_W-1){1'b0}}}
                                      : {1'b0, {(POT_W-1){1'b1}}};
        end
        spike     = v_sat > thr_reg;
        mode1_div = mode_reg && (thr_reg > rst_lvl_reg);
    end

    // remainder step: trial subtract of the shifted partial remainder
    logic [POT_W:0]           div_trial;
    logic                     div_ge;
    logic [POT_W-1:0]         div_rem_new;

    always_comb
    begin
        div_trial   = {rem_reg, num_reg[POT_W-1]};
        div_ge      = div_trial >= {1'b0, den_reg};
        div_rem_new = div_ge ? POT_W'(div_trial - {1'b0, den_reg})
                             : div_trial[POT_W-1:0];
    end

    // potential to store: rst + ((v - thr - 1) mod (thr - rst)) + 1
    logic signed [POT_W-1:0]  fin_v;

    assign fin_v = div_used_reg ? (rst_lvl_reg + rem_reg + POT_W'(1)) : v_reg;

    // ---------------------------------------------------------------
    // state machine
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        mem_waddr     = AW'({{(IDX_EXT_W-IDX_W){1'b0}}, idx_reg});
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(NUM_NEURONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (in_range_reg && !refr_hit_reg && spike && mode1_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    mem_we     = in_range_reg && !refr_flag_reg;
                    mem_wdata  = {rd_has | spk_reg,
                                  spk_reg ? now_reg : rd_last,
                                  fin_v};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // neuron state memory, registered read
    // ---------------------------------------------------------------
    logic [MEM_W-1:0]         state_mem [NUM_NEURONS];
    logic [IDX_EXT_W-1:0]     s_idx_ext;

    assign s_idx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, s_axis_tdata[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            state_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_reg <= state_mem[s_idx_ext[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg      <= s_axis_tdata[IDX_W-1:0];
            dv_reg       <= s_axis_tdata[IDX_W+POT_W-1:IDX_W];
            now_reg      <= s_axis_tdata[IDX_W+POT_W+STEP_W-1:IDX_W+POT_W];
            in_range_reg <= s_idx_ext < IDX_EXT_W'(NUM_NEURONS);
        end

        // decay multiply and refractory window check
        if (state_reg == ST_MUL)
        begin
            prod_reg     <= rd_pot * $signed({1'b0, decay_reg});
            refr_hit_reg <= rd_has &&
                            ((now_reg - rd_last) <= {{(STEP_W-REFR_W){1'b0}}, refr_steps_reg});
        end

        if (state_reg == ST_ADD)
        begin
            spk_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            refr_flag_reg <= 1'b0;
            div_used_reg  <= 1'b0;
            num_reg       <= POT_W'(v_sat - thr_reg - POT_W'(1));
            den_reg       <= POT_W'(thr_reg - rst_lvl_reg);
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            if (!in_range_reg)
            begin
                v_reg <= '0;
            end
            else if (refr_hit_reg)
            begin
                // frozen: keep the stored potential
                v_reg         <= rd_pot;
                refr_flag_reg <= 1'b1;
            end
            else if (spike)
            begin
                spk_reg <= 1'b1;
                if (mode1_div)
                begin
                    v_reg        <= v_sat;
                    sat_reg      <= sum_sat;
                    div_used_reg <= 1'b1;
                end
                else
                begin
                    // mode 0, or mode 1 clamped when threshold is not above reset
                    v_reg   <= rst_lvl_reg;
                    sat_reg <= sum_sat | mode_reg;
                end
            end
            else
            begin
                v_reg   <= v_sat;
                sat_reg <= sum_sat;
            end
        end

        if (state_reg == ST_DIV)
        begin
            rem_reg     <= div_rem_new;
            num_reg     <= {num_reg[POT_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end

        if (load_out)
        begin
            out_data_reg <= {3'b000, sat_reg, fin_v, refr_flag_reg, spk_reg, idx_reg};
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
`ifndef SYNTH
    // no state write while a new item reads the memory
    a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !in_accept)
        else $error("state write overlaps accept");

    // the remainder unit never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("remainder unit with zero divisor");

    // a result only appears after write back
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside write back");

    // a spiking neuron ends at or below threshold unless it is set to reset level
    a_below_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && spk_reg) |-> (fin_v <= thr_reg || fin_v == rst_lvl_reg))
        else $error("potential above threshold after reset");
`endif

endmodule
